### rtl/core/xorshift_add_prng_8x32_macros.svh
// Assertion macros shared by the generator RTL.
// XAP_ASSERT_SAME checks the consequent in the same cycle as the antecedent.
// XAP_ASSERT_NEXT checks the consequent in the cycle after the antecedent.
`ifndef XORSHIFT_ADD_PRNG_8X32_MACROS_SVH
`define XORSHIFT_ADD_PRNG_8X32_MACROS_SVH

`ifndef NO_ASSERTIONS

`define XAP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("generator assertion failed");

`define XAP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("generator assertion failed");

`else

`define XAP_ASSERT_SAME(label, ante, cons)

`define XAP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/core/xapr_pkg.sv
package xapr_pkg;

    typedef logic [31:0] word_t;
    typedef logic [7:0][31:0] words_t;

    // Seed scrambling multiplier.
    localparam word_t SEED_MULT = 32'h2545_F492;

    // Generator words after reset, word 7 first.
    localparam words_t RESET_WORDS = {
        32'h8765_4321, 32'h1234_5678, 32'hA5A5_A5A5, 32'h3D62_7E37,
        32'h7F4A_7C15, 32'hEAD3_D6C8, 32'h0620_81DE, 32'hBAD5_EED1
    };

    // One xorshift step (right 13, left 17, right 5) on the running seed.
    function automatic word_t seed_scramble(input word_t s);
        word_t a;
        word_t b;
        begin
            a = s ^ (s >> 13);
            b = a ^ (a << 17);
            return b ^ (b >> 5);
        end
    endfunction

    // Output word: rotl(w1 * 5, 7) * 9, built from shifts and adds.
    function automatic word_t draw_out(input word_t w1);
        word_t m5;
        word_t r;
        begin
            m5 = w1 + (w1 << 2);
            r  = {m5[24:0], m5[31:25]};
            return r + (r << 3);
        end
    endfunction

    // One state advance of the eight words.
    function automatic words_t draw_update(input words_t w_in);
        words_t w;
        word_t  t;
        begin
            w = w_in;
            t = w[1] << 9;
            w[2] = w[2] ^ w[0];
            w[5] = w[5] + w[1];
            w[1] = w[1] ^ w[2];
            w[7] = w[7] ^ w[3];
            w[3] = w[3] + w[4];
            w[4] = w[4] ^ w[5];
            w[0] = w[0] ^ w[6];
            w[6] = w[6] ^ w[7];
            w[6] = w[6] ^ t;
            w[2] = {w[2][20:0], w[2][31:21]};
            return w;
        end
    endfunction

endpackage

### rtl/core/xorshift_add_prng_8x32.sv
// Channel  | Group          | Contents
// request  | s_axis_t*      | tuser: cmd (0 reseed, 1 draw); tdata: seed_value
// result   | m_axis_t*      | tdata: random_value (one per draw, none per reseed)
//
// A draw's result is shown in the cycle after it is accepted; draws can be accepted
// every cycle while results are taken. A reseed holds s_axis_tready low after it is
// accepted: the seed scrambler and multiplier fill the eight words in turn, then the
// word updater makes WARMUP_DRAWS warm-up passes.
// Reset loads the fixed word constants and clears the running seed; no clearing pass.
// The result register holds a word while m_axis_tready is low; a draw waits for it.
`include "xorshift_add_prng_8x32_macros.svh"

module xorshift_add_prng_8x32 #(
    parameter int WARMUP_DRAWS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,   // [31:0] seed_value
    input  logic [0:0]           s_axis_tuser,   // [0] cmd
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output xapr_pkg::word_t      m_axis_tdata    // [31:0] random_value
);

    import xapr_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SEED = 2'd1;
    localparam logic [1:0] ST_WARM = 2'd2;

    localparam logic CMD_RESEED = 1'b0;
    localparam logic CMD_DRAW   = 1'b1;

    localparam int WCW = (WARMUP_DRAWS > 0) ? $clog2(WARMUP_DRAWS + 1) : 1;

    logic [1:0]     state_reg, state_next;
    logic [2:0]     step_reg, step_next;
    logic [WCW-1:0] warm_reg, warm_next;
    word_t          seed_reg, seed_next;
    words_t         words_reg, words_next;
    logic           out_valid_reg, out_valid_next;
    word_t          out_data_reg, out_data_next;

    logic   req_accept;
    word_t  seed_step;
    word_t  seed_word;
    words_t words_adv;

    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign req_accept    = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Shared seed unit: scramble, then multiply and add the word index.
    assign seed_step = seed_scramble(seed_reg);
    assign seed_word = word_t'(seed_step * SEED_MULT) + word_t'(step_reg);

    // Shared word updater, used by draws and warm-up passes alike.
    assign words_adv = draw_update(words_reg);

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        warm_next      = warm_reg;
        seed_next      = seed_reg;
        words_next     = words_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    if (s_axis_tuser[0] == CMD_DRAW)
                    begin
                        out_data_next  = draw_out(words_reg[1]);
                        words_next     = words_adv;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        seed_next  = s_axis_tdata;
                        step_next  = 3'd0;
                        state_next = ST_SEED;
                    end
                end
            end
            ST_SEED:
            begin
                seed_next            = seed_step;
                words_next[step_reg] = seed_word;
                step_next            = step_reg + 3'd1;
                if (step_reg == 3'd7)
                begin
                    if (WARMUP_DRAWS > 0)
                    begin
                        warm_next  = WCW'(WARMUP_DRAWS);
                        state_next = ST_WARM;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_WARM:
            begin
                words_next = words_adv;
                warm_next  = warm_reg - WCW'(1);
                if (warm_reg == WCW'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 3'd0;
            warm_reg      <= '0;
            seed_reg      <= '0;
            words_reg     <= RESET_WORDS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            warm_reg      <= warm_next;
            seed_reg      <= seed_next;
            words_reg     <= words_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    // A reseed keeps the request side busy on the next cycle.
    `XAP_ASSERT_NEXT(a_reseed_busy, req_accept && (s_axis_tuser[0] == CMD_RESEED), !s_axis_tready)
    // An accepted draw shows a result on the next cycle.
    `XAP_ASSERT_NEXT(a_draw_result, req_accept && (s_axis_tuser[0] == CMD_DRAW), m_axis_tvalid)
    // Seeding and warm-up never raise a result.
    `XAP_ASSERT_NEXT(a_no_result_busy, state_reg != ST_IDLE, !$rose(m_axis_tvalid))

endmodule
